// File: src/flcr_pkg.sv
// Shared types, character codes and lookup functions of the LED command responder.
`default_nettype none

package flcr_pkg;

    // Character codes
    localparam logic [7:0] CH_AT    = 8'h40;   // '@'
    localparam logic [7:0] CH_AMP   = 8'h26;   // '&'
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;   // '1'
    localparam logic [7:0] CH_UPL   = 8'h4C;   // 'L'
    localparam logic [7:0] CH_UPS   = 8'h53;   // 'S'
    localparam logic [7:0] CH_L     = 8'h6C;   // 'l'
    localparam logic [7:0] CH_E     = 8'h65;   // 'e'
    localparam logic [7:0] CH_UNDER = 8'h5F;   // '_'
    localparam logic [7:0] CH_O     = 8'h6F;   // 'o'
    localparam logic [7:0] CH_N     = 8'h6E;   // 'n'
    localparam logic [7:0] CH_F     = 8'h66;   // 'f'

    // Frame matching
    localparam int         CMD_COUNT = 6;
    localparam logic [3:0] CMD_LEN   = 4'd7;
    localparam logic [3:0] POS_MAX   = 4'd15;
    localparam logic [5:0] ALL_CANDIDATES = 6'h3F;
    localparam logic [2:0] SEL_LAST  = 3'd5;

    // Acknowledgment is always nine characters long
    localparam logic [3:0] ACK_LEN   = 4'd9;

    // Count field width in the queue entry, the widest counter supported
    localparam int COUNT_W_MAX = 16;
    // Decimal digits of the widest count
    localparam logic [2:0] MAX_DIGITS = 3'd5;
    // v / 10 == (v * 0xCCCD) >> 19 for every 16-bit v
    localparam logic [15:0] DIV10_MUL = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    // One reply job handed from the front to the back
    typedef struct packed {
        logic                   is_press;
        logic [1:0]             led_idx;
        logic                   off;
        logic [1:0]             button;
        logic [COUNT_W_MAX-1:0] count;
        logic [2:0]             leds;
    } job_t;

    // Character at position pos of command k ("@leN_on" / "@leN_of")
    function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_AT;
            3'd1:    c = CH_L;
            3'd2:    c = CH_E;
            3'd3:    c = CH_ONE + {6'd0, k[2:1]};
            3'd4:    c = CH_UNDER;
            3'd5:    c = CH_O;
            3'd6:    c = k[0] ? CH_F : CH_N;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Character at position pos of the acknowledgment "@LleN_on&" / "@LleN_of&"
    function automatic logic [7:0] ack_char(input logic [3:0] pos, input logic [1:0] led,
                                            input logic off);
        logic [7:0] c;
        case (pos)
            4'd0:    c = CH_AT;
            4'd1:    c = CH_UPL;
            4'd2:    c = CH_L;
            4'd3:    c = CH_E;
            4'd4:    c = CH_ONE + {6'd0, led};
            4'd5:    c = CH_UNDER;
            4'd6:    c = CH_O;
            4'd7:    c = off ? CH_F : CH_N;
            default: c = CH_AMP;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/flcr_fifo.sv
// Short register queue of reply jobs between the front and the back.
`default_nettype none

module flcr_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire flcr_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output flcr_pkg::job_t     pop_data,
    output logic               empty
);
    import flcr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue occupancy beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");

endmodule

`default_nettype wire

// File: src/flcr_front.sv
// Front part: accepts requests, tracks frames, LEDs and press counters, queues reply jobs.
`default_nettype none

module flcr_front #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire logic           operation,
    input  wire logic [7:0]     rx_byte,
    input  wire logic [1:0]     button_index,
    output logic                push,
    output flcr_pkg::job_t      push_data,
    input  wire logic           full
);
    import flcr_pkg::*;

    logic [3:0]               pos_reg, pos_next;
    logic [5:0]               cand_reg, cand_next;
    logic [2:0]               led_reg, led_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg [3];
    logic [COUNTER_WIDTH-1:0] cnt_next [3];

    logic                     accept;
    logic [3:0]               pos_w;
    logic [5:0]               cand_w;
    logic [2:0]               sel;
    logic [COUNTER_WIDTH-1:0] cnt_inc;

    assign req_stall = full;
    assign accept    = req_valid && !full;

    // Classify the request and update frame, LED and counter state
    always_comb
    begin
        pos_next  = pos_reg;
        cand_next = cand_reg;
        led_next  = led_reg;
        cnt_next  = cnt_reg;
        push      = 1'b0;
        push_data = '0;
        pos_w     = pos_reg;
        cand_w    = cand_reg;
        sel       = SEL_LAST;
        cnt_inc   = '0;
        if (accept && !operation)
        begin
            // Restart on '@'
            if (rx_byte == CH_AT)
            begin
                pos_w  = '0;
                cand_w = ALL_CANDIDATES;
            end
            // Drop commands that no longer match
            if (pos_w < CMD_LEN)
            begin
                for (int k = 0; k < CMD_COUNT; k++)
                begin
                    if (cmd_char(3'(k), pos_w[2:0]) != rx_byte)
                    begin
                        cand_w[k] = 1'b0;
                    end
                end
            end
            if (pos_w < POS_MAX)
            begin
                pos_w = pos_w + 1'b1;
            end
            // First matching command wins
            for (int k = CMD_COUNT - 2; k >= 0; k--)
            begin
                if (cand_w[k])
                begin
                    sel = 3'(k);
                end
            end
            // Close the frame on '&'
            if (rx_byte == CH_AMP)
            begin
                if (pos_w > CMD_LEN && cand_w != '0)
                begin
                    if (sel[0])
                    begin
                        led_next = led_reg & ~(3'b001 << sel[2:1]);
                    end
                    else
                    begin
                        led_next = led_reg | (3'b001 << sel[2:1]);
                    end
                    push               = 1'b1;
                    push_data.is_press = 1'b0;
                    push_data.led_idx  = sel[2:1];
                    push_data.off      = sel[0];
                    push_data.leds     = led_next;
                end
                pos_w  = '0;
                cand_w = ALL_CANDIDATES;
            end
            pos_next  = pos_w;
            cand_next = cand_w;
        end
        else if (accept && operation)
        begin
            case (button_index)
                2'd0, 2'd1, 2'd2:
                begin
                    cnt_inc                = cnt_reg[button_index] + 1'b1;
                    cnt_next[button_index] = cnt_inc;
                    push                   = 1'b1;
                    push_data.is_press     = 1'b1;
                    push_data.button       = button_index;
                    push_data.count        = COUNT_W_MAX'(cnt_inc);
                    push_data.leds         = led_reg;
                end
                default:
                begin
                    // Ignore a press of a button that does not exist
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cand_reg <= ALL_CANDIDATES;
            led_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg  <= pos_next;
            cand_reg <= cand_next;
            led_reg  <= led_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/flcr_back.sv
// Back part: takes reply jobs, converts counts to decimal and sends reply characters.
`default_nettype none

module flcr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    input  wire flcr_pkg::job_t pop_data,
    output logic                pop,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output logic [7:0]          tx_byte,
    output logic                last_byte,
    output logic [2:0]          led_state
);
    import flcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    job_t                   job_reg, job_next;
    logic [COUNT_W_MAX-1:0] val_reg, val_next;
    logic [3:0]             dig_reg [5];
    logic [2:0]             nd_reg, nd_next;
    logic [3:0]             pos_reg, pos_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic                   out_last_reg, out_last_next;
    logic [2:0]             out_leds_reg, out_leds_next;

    logic                   out_free;
    logic [31:0]            prod;
    logic [COUNT_W_MAX-1:0] quot;
    logic [COUNT_W_MAX-1:0] rem_full;
    logic                   dig_wr;
    logic [3:0]             len;
    logic [3:0]             dig_sel;
    logic [7:0]             ch;

    assign rsp_valid = out_valid_reg;
    assign tx_byte   = out_byte_reg;
    assign last_byte = out_last_reg;
    assign led_state = out_leds_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Divide by ten through the reciprocal
    assign prod     = val_reg * DIV10_MUL;
    assign quot     = COUNT_W_MAX'(prod[31:DIV10_SHIFT]);
    assign rem_full = val_reg - ((quot << 3) + (quot << 1));

    // Pick the character at the current reply position
    always_comb
    begin
        len     = job_reg.is_press ? (4'd4 + {1'b0, nd_reg}) : ACK_LEN;
        dig_sel = {1'b0, nd_reg} + 4'd2 - pos_reg;
        if (!job_reg.is_press)
        begin
            ch = ack_char(pos_reg, job_reg.led_idx, job_reg.off);
        end
        else if (pos_reg == 4'd0)
        begin
            ch = CH_AT;
        end
        else if (pos_reg == 4'd1)
        begin
            ch = CH_UPS;
        end
        else if (pos_reg == 4'd2)
        begin
            ch = CH_ZERO + {6'd0, job_reg.button};
        end
        else if (pos_reg == len - 4'd1)
        begin
            ch = CH_AMP;
        end
        else
        begin
            ch = CH_ZERO + {4'd0, dig_reg[dig_sel[2:0]]};
        end
    end

    // Sequence: fetch job, convert the count of a press, send characters
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        val_next       = val_reg;
        nd_next        = nd_reg;
        pos_next       = pos_reg;
        pop            = 1'b0;
        dig_wr         = 1'b0;
        out_valid_next = out_valid_reg && rsp_stall;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_leds_next  = out_leds_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    job_next   = pop_data;
                    val_next   = pop_data.count;
                    nd_next    = '0;
                    pos_next   = '0;
                    state_next = pop_data.is_press ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV:
            begin
                dig_wr   = 1'b1;
                nd_next  = nd_reg + 1'b1;
                val_next = quot;
                if (quot == '0 || nd_next == MAX_DIGITS)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ch;
                    out_last_next  = (pos_reg == len - 4'd1);
                    out_leds_next  = job_reg.leds;
                    pos_next       = pos_reg + 1'b1;
                    if (pos_reg == len - 4'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold job, count and output payload
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        val_reg      <= val_next;
        nd_reg       <= nd_next;
        pos_reg      <= pos_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_leds_reg <= out_leds_next;
        if (dig_wr)
        begin
            dig_reg[nd_reg] <= rem_full[3:0];
        end
    end

    a_last_is_amp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && last_byte) |-> (tx_byte == CH_AMP))
        else $error("reply ends on a character other than the closing mark");

    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (nd_reg < MAX_DIGITS && rem_full < 16'd10))
        else $error("decimal conversion out of range");

endmodule

`default_nettype wire

// File: src/framed_led_command_responder.sv
// Top level of the framed LED command responder: front, job queue and back.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   req     | req_valid/req_stall  | operation, rx_byte, button_index
//   rsp     | rsp_valid/rsp_stall  | tx_byte, last_byte, led_state
//
// The front takes one request per cycle while the job queue has room.
// In the back an acknowledgment is a fetch of the job and then its nine characters.
// A press reply with a count of D decimal digits is a fetch, then the divide-by-ten step
// that yields one digit per cycle, then 4 + D characters.
// Reset clears frame state, LEDs, counters, the queue and the output valid flag.
// A stall on rsp holds the output register; the queue then fills and raises req_stall.
`default_nettype none

module framed_led_command_responder #(
    parameter int COUNTER_WIDTH = 16,
    parameter int QUEUE_DEPTH   = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic       operation,
    input  wire logic [7:0] rx_byte,
    input  wire logic [1:0] button_index,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output logic [7:0]      tx_byte,
    output logic            last_byte,
    output logic [2:0]      led_state
);
    import flcr_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t push_data;
    job_t pop_data;

    flcr_front #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .button_index (button_index),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    flcr_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    flcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .tx_byte   (tx_byte),
        .last_byte (last_byte),
        .led_state (led_state)
    );

endmodule

`default_nettype wire
